// ----- hdl/ctm_pkg.sv -----
// Shared types and constants for the cone track midpoint engine.
// No dependencies.
package ctm_pkg;

    localparam logic [1:0] CMD_LEFT    = 2'd0;
    localparam logic [1:0] CMD_RIGHT   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Classified operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_LOAD_L  = 2'd0,
        OP_LOAD_R  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

endpackage

// ----- hdl/cone_track_midpoint_engine.sv -----
// Top level of the cone track midpoint engine.
// Instantiates ctm_front and ctm_back; uses ctm_pkg.
//
// channel  | handshake         | payload
// in       | in_valid/in_stall | command, pos_x, pos_y
// out      | out_valid/out_stall | mid_x, mid_y, final_point, cones_dropped
//
// A load registers the key squares, forms the norm, then shifts one list entry per step in the insertion sort.
// A compute emits each point through a read step (S_EMIT_RD) and an output step (S_EMIT_OUT) that saturates it.
// Reset clears counts and the drop flag; the cone rows are not cleared.
// A stalled output holds the back end; the 2-entry queue then fills and stalls input.
module cone_track_midpoint_engine #(
    parameter int MAX_CONES  = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] mid_x,
    output logic signed [COORD_BITS-1:0] mid_y,
    output logic                         final_point,
    output logic                         cones_dropped
);
    logic                  q_valid, q_pop;
    ctm_pkg::op_t          q_op;
    logic [COORD_BITS-1:0] q_x, q_y;

    ctm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .command(command), .pos_x(pos_x), .pos_y(pos_y),
        .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_x(q_x), .q_y(q_y)
    );

    ctm_back #(.MAX_CONES(MAX_CONES), .COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op),
        .q_x(q_x), .q_y(q_y), .valid(out_valid), .stall(out_stall),
        .mid_x(mid_x), .mid_y(mid_y), .final_point(final_point),
        .cones_dropped(cones_dropped)
    );
endmodule

// ----- hdl/ctm_front.sv -----
// Front end: accepts input transactions, drops unused commands,
// and pushes classified operations into a two-entry queue. Uses ctm_pkg.
module ctm_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    output logic                         stall,
    input  logic [1:0]                   command,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    output logic                         q_valid,
    input  logic                         q_pop,
    output ctm_pkg::op_t                 q_op,
    output logic [COORD_BITS-1:0]        q_x,
    output logic [COORD_BITS-1:0]        q_y
);
    ctm_pkg::op_t          op_reg [2];
    logic [COORD_BITS-1:0] x_reg [2];
    logic [COORD_BITS-1:0] y_reg [2];
    logic                  wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  push, pop;
    ctm_pkg::op_t          op_dec;

    assign stall   = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = op_reg[rp_reg];
    assign q_x     = x_reg[rp_reg];
    assign q_y     = y_reg[rp_reg];

    // command decode; code 3 is accepted and discarded
    always_comb
    begin
        unique case (command)
            ctm_pkg::CMD_LEFT:    op_dec = ctm_pkg::OP_LOAD_L;
            ctm_pkg::CMD_RIGHT:   op_dec = ctm_pkg::OP_LOAD_R;
            default:              op_dec = ctm_pkg::OP_COMPUTE;
        endcase
    end

    assign push    = valid && !stall && (command != ctm_pkg::CMD_NONE);
    assign pop     = q_valid && q_pop;
    assign wp_next = push ? ~wp_reg : wp_reg;
    assign rp_next = pop ? ~rp_reg : rp_reg;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wp_reg] <= op_dec;
            x_reg[wp_reg]  <= pos_x;
            y_reg[wp_reg]  <= pos_y;
        end
    end
endmodule

// ----- hdl/ctm_back.sv -----
// Back end: cone stores, insertion sort, point emission with output register.
// Uses ctm_pkg.
module ctm_back #(
    parameter int MAX_CONES  = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  ctm_pkg::op_t                 q_op,
    input  logic [COORD_BITS-1:0]        q_x,
    input  logic [COORD_BITS-1:0]        q_y,
    output logic                         valid,
    input  logic                         stall,
    output logic signed [COORD_BITS-1:0] mid_x,
    output logic signed [COORD_BITS-1:0] mid_y,
    output logic                         final_point,
    output logic                         cones_dropped
);
    localparam int AW = $clog2(MAX_CONES);
    localparam int CW = $clog2(MAX_CONES + 1);
    localparam int NW = 2 * COORD_BITS + 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_CONES);
    localparam logic signed [COORD_BITS:0] SMAX = {2'b00, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS:0] SMIN = {2'b11, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_LREAD, S_LSHIFT, S_EMIT0, S_EMIT_RD, S_EMIT_OUT
    } state_t;

    // each list is a row of registers kept sorted on insert
    logic [COORD_BITS-1:0] lx_reg [MAX_CONES];
    logic [COORD_BITS-1:0] ly_reg [MAX_CONES];
    logic [NW-1:0]         ln_reg [MAX_CONES];
    logic [COORD_BITS-1:0] rx_reg [MAX_CONES];
    logic [COORD_BITS-1:0] ry_reg [MAX_CONES];
    logic [NW-1:0]         rn_reg [MAX_CONES];

    state_t                state_reg;
    logic [CW-1:0]         lcnt_reg, rcnt_reg, idx_reg, num_reg;
    logic                  ovf_reg, side_reg;
    logic [COORD_BITS-1:0] kx_reg, ky_reg;
    logic [NW-1:0]         kn_reg;
    logic [2*COORD_BITS-1:0] sqx_reg, sqy_reg;
    logic                  vld_reg, fin_reg, drp_reg, single_reg, useleft_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic signed [COORD_BITS:0]   ax_reg, ay_reg;

    logic [COORD_BITS-1:0] absx, absy;
    logic [AW-1:0]         ia;
    logic signed [COORD_BITS:0] ex, ey;
    logic                  out_free;
    logic                  single_now, both_empty, load_out;

    assign valid         = vld_reg;
    assign mid_x         = ox_reg;
    assign mid_y         = oy_reg;
    assign final_point   = fin_reg;
    assign cones_dropped = drp_reg;
    assign out_free      = !vld_reg || !stall;
    assign absx  = q_x[COORD_BITS-1] ? -q_x : q_x;
    assign absy  = q_y[COORD_BITS-1] ? -q_y : q_y;
    assign ia    = idx_reg[AW-1:0];

    assign single_now = (lcnt_reg != '0) != (rcnt_reg != '0);
    assign both_empty = (lcnt_reg == '0) && (rcnt_reg == '0);
    // output register takes a new point: origin point or a computed one
    assign load_out   = out_free && ((state_reg == S_EMIT0 && !single_now)
                                     || state_reg == S_EMIT_OUT);

    // compute leaves the queue together with its last point
    assign q_pop = ((state_reg == S_IDLE) && q_valid && q_op != ctm_pkg::OP_COMPUTE)
                   || (out_free && ((state_reg == S_EMIT_OUT && idx_reg == num_reg)
                                    || (state_reg == S_EMIT0 && both_empty)));

    // element to emit: x offset from head (y as stored) in single-list mode, else pair average
    always_comb
    begin
        if (single_reg)
        begin
            ex = useleft_reg
                ? $signed({lx_reg[ia][COORD_BITS-1], lx_reg[ia]})
                  - $signed({lx_reg[0][COORD_BITS-1], lx_reg[0]})
                : $signed({rx_reg[ia][COORD_BITS-1], rx_reg[ia]})
                  - $signed({rx_reg[0][COORD_BITS-1], rx_reg[0]});
            ey = useleft_reg ? $signed({ly_reg[ia][COORD_BITS-1], ly_reg[ia]})
                             : $signed({ry_reg[ia][COORD_BITS-1], ry_reg[ia]});
        end
        else
        begin
            ex = $signed({lx_reg[ia][COORD_BITS-1], lx_reg[ia]})
               + $signed({rx_reg[ia][COORD_BITS-1], rx_reg[ia]});
            ey = $signed({ly_reg[ia][COORD_BITS-1], ly_reg[ia]})
               + $signed({ry_reg[ia][COORD_BITS-1], ry_reg[ia]});
            ex = ex >>> 1;
            ey = ey >>> 1;
        end
    end

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [COORD_BITS:0] v);
        if (v > SMAX) sat = SMAX[COORD_BITS-1:0];
        else if (v < SMIN) sat = SMIN[COORD_BITS-1:0];
        else sat = v[COORD_BITS-1:0];
    endfunction

    // control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lcnt_reg    <= '0;
            rcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            vld_reg     <= 1'b0;
            idx_reg     <= '0;
            num_reg     <= '0;
            side_reg    <= 1'b0;
            single_reg  <= 1'b0;
            useleft_reg <= 1'b0;
            ax_reg      <= '0;
            ay_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            fin_reg     <= 1'b0;
            drp_reg     <= 1'b0;
        end
        else
        begin
            // output register: load a point, or empty it on acceptance
            if (load_out)
            begin
                vld_reg <= 1'b1;
                drp_reg <= ovf_reg;
                if (state_reg == S_EMIT0)
                begin
                    ox_reg  <= '0;
                    oy_reg  <= '0;
                    fin_reg <= both_empty;
                end
                else
                begin
                    ox_reg  <= sat(ax_reg);
                    oy_reg  <= sat(ay_reg);
                    fin_reg <= (idx_reg == num_reg);
                end
            end
            else if (vld_reg && !stall)
            begin
                vld_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_op == ctm_pkg::OP_COMPUTE)
                        begin
                            state_reg <= S_EMIT0;
                        end
                        else if ((q_op == ctm_pkg::OP_LOAD_L ? lcnt_reg : rcnt_reg) == FULL)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            side_reg  <= (q_op == ctm_pkg::OP_LOAD_R);
                            idx_reg   <= (q_op == ctm_pkg::OP_LOAD_L) ? lcnt_reg : rcnt_reg;
                            state_reg <= S_LREAD;
                        end
                    end
                end
                S_LREAD:
                begin
                    // norm is formed from the registered squares
                    state_reg <= S_LSHIFT;
                end
                S_LSHIFT:
                begin
                    // one slot per cycle: move larger neighbor up, or place key
                    if (idx_reg != '0 &&
                        kn_reg < (side_reg ? rn_reg[ia - 1'b1] : ln_reg[ia - 1'b1]))
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                    else
                    begin
                        if (side_reg) rcnt_reg <= rcnt_reg + 1'b1;
                        else          lcnt_reg <= lcnt_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT0:
                begin
                    single_reg  <= single_now;
                    useleft_reg <= (lcnt_reg != '0);
                    idx_reg     <= '0;
                    if (single_now)
                    begin
                        num_reg   <= (lcnt_reg != '0) ? lcnt_reg : rcnt_reg;
                        state_reg <= S_EMIT_RD;
                    end
                    else if (out_free)
                    begin
                        // origin point goes out now; pairs follow
                        num_reg <= (lcnt_reg < rcnt_reg) ? lcnt_reg : rcnt_reg;
                        if (both_empty)
                        begin
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_EMIT_RD:
                begin
                    ax_reg    <= ex;
                    ay_reg    <= ey;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        if (idx_reg == num_reg)
                        begin
                            // last point loaded; finish run
                            lcnt_reg  <= '0;
                            rcnt_reg  <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload path: squares, shifting, key insert
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            kx_reg  <= q_x;
            ky_reg  <= q_y;
            sqx_reg <= absx * absx;
            sqy_reg <= absy * absy;
        end
        if (state_reg == S_LREAD)
            kn_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        if (state_reg == S_LSHIFT)
        begin
            if (idx_reg != '0 &&
                kn_reg < (side_reg ? rn_reg[ia - 1'b1] : ln_reg[ia - 1'b1]))
            begin
                if (side_reg)
                begin
                    rx_reg[ia] <= rx_reg[ia - 1'b1];
                    ry_reg[ia] <= ry_reg[ia - 1'b1];
                    rn_reg[ia] <= rn_reg[ia - 1'b1];
                end
                else
                begin
                    lx_reg[ia] <= lx_reg[ia - 1'b1];
                    ly_reg[ia] <= ly_reg[ia - 1'b1];
                    ln_reg[ia] <= ln_reg[ia - 1'b1];
                end
            end
            else if (side_reg)
            begin
                rx_reg[ia] <= kx_reg;
                ry_reg[ia] <= ky_reg;
                rn_reg[ia] <= kn_reg;
            end
            else
            begin
                lx_reg[ia] <= kx_reg;
                ly_reg[ia] <= ky_reg;
                ln_reg[ia] <= kn_reg;
            end
        end
    end
endmodule

// ----- hdl/ctm_checker.sv -----
// Port-level checker for cone_track_midpoint_engine, bound to the top level.
// No package dependencies.
module ctm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic final_point,
    input logic cones_dropped
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input transaction withdrawn while stalled");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(final_point))
        else $error("final flag changed while stalled");
    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cones_dropped))
        else $error("drop flag changed while stalled");
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");
endmodule

bind cone_track_midpoint_engine ctm_checker u_ctm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .final_point(final_point), .cones_dropped(cones_dropped)
);
